// ===== hw/rtl/mpts_pkg.sv =====
// ---------------------------------------------------------------------------
// mpts_pkg: shared types and constants for the pulse train scheduler
// Holds result/request codes, the per-channel record layout, the
// controller/datapath command and status bundles, and a saturating adder.
// ---------------------------------------------------------------------------
package mpts_pkg;

   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 24;
   localparam int EDGE_W   = 7;

   // request limits and levels
   localparam logic [7:0]          MAX_PULSES = 8'd50;
   localparam logic [15:0]         MAX_MS     = 16'd10000;
   localparam logic [5:0]          ON_LEVEL   = 6'd60;
   localparam logic [5:0]          OFF_LEVEL  = 6'd0;
   localparam logic [9:0]          US_PER_MS  = 10'd1000;
   localparam logic [PERIOD_W-1:0] HOLD_RESET = 24'd5000000;

   // results per tick, and number of devices covered by the mask register
   localparam logic [5:0] MAX_RES   = 6'd32;
   localparam logic [3:0] MASK_DEVS = 4'd4;

   // input item kinds
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // result kinds
   localparam logic [1:0] RES_STATUS   = 2'd0;
   localparam logic [1:0] RES_FORCE_ON = 2'd1;
   localparam logic [1:0] RES_LEVEL    = 2'd2;

   // status codes
   localparam logic ST_ACCEPT = 1'b0;
   localparam logic ST_REJECT = 1'b1;

   // configuration register indexes
   localparam logic CSR_ACTIVE_MASK = 1'b0;
   localparam logic CSR_HOLD_DELAY  = 1'b1;

   // per-channel record stored in the channel memory
   typedef struct packed {
      logic [EDGE_W-1:0]   rem_edges;
      logic [PERIOD_W-1:0] period_us;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   next_change;
   } chan_entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic set_check;
      logic set_load;
      logic set_store;
      logic walk_step;
      logic walk_finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic set_reject;
      logic walk_done;
   } dp_sts_type;

   // 48-bit add that saturates at all ones
   function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/mpts_ram.sv =====
// ---------------------------------------------------------------------------
// mpts_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module mpts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mpts_ctrl.sv =====
// ---------------------------------------------------------------------------
// mpts_ctrl: sequencing state machine
// Accepts items, runs a set request through check/load/store (a rejected one
// stops at check) and a tick's channel walk until the datapath reports it done.
// ---------------------------------------------------------------------------
module mpts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_kind,
   output logic                  busy,
   output mpts_pkg::dp_cmd_type  cmd,
   input  mpts_pkg::dp_sts_type  sts
);
   import mpts_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SET_CHECK,
      SET_LOAD,
      SET_STORE,
      TICK_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = (req_kind == REQ_TICK) ? TICK_WALK : SET_CHECK;
            end
         end
         SET_CHECK: begin
            cmd.set_check = 1'b1;
            state_in      = sts.set_reject ? IDLE : SET_LOAD;
         end
         SET_LOAD: begin
            cmd.set_load = 1'b1;
            state_in     = SET_STORE;
         end
         SET_STORE: begin
            cmd.set_store = 1'b1;
            state_in      = IDLE;
         end
         TICK_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) begin
               cmd.walk_finish = 1'b1;
               state_in        = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// ===== hw/rtl/mpts_dp.sv =====
// ---------------------------------------------------------------------------
// mpts_dp: scheduler datapath
// Request registers, configuration registers, channel memory with valid
// bits, the one-channel-per-cycle walk pipeline and the result register.
// ---------------------------------------------------------------------------
module mpts_dp #(
   parameter int DEVICES = 4,
   parameter int PORTS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpts_pkg::dp_cmd_type  cmd,
   output mpts_pkg::dp_sts_type  sts,
   input  logic [7:0]            req_device,
   input  logic [7:0]            req_port,
   input  logic [7:0]            req_num_pulses,
   input  logic [15:0]           req_pulse_time_ms,
   input  logic                  req_port_is_on,
   input  logic [47:0]           req_time_us,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [23:0]           csr_wdata,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_result_kind,
   output logic [1:0]            rsp_out_device,
   output logic [3:0]            rsp_out_port,
   output logic [5:0]            rsp_level,
   output logic                  rsp_status,
   output logic                  rsp_last
);
   import mpts_pkg::*;

   localparam int NCH     = DEVICES * PORTS;
   localparam int CH_W    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int DEV_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int PORT_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int ENTRY_W = $bits(chan_entry_type);

   localparam logic [7:0]        DEV_LIM   = 8'(DEVICES);
   localparam logic [7:0]        PORT_LIM  = 8'(PORTS);
   localparam logic [CH_W:0]     NCH_CNT   = (CH_W + 1)'(NCH);
   localparam logic [CH_W-1:0]   PORTS_CH  = CH_W'(PORTS);
   localparam logic [PORT_W-1:0] PORT_LAST = PORT_W'(PORTS - 1);

   // configuration
   logic [3:0]          mask_ff, mask_in;
   logic [PERIOD_W-1:0] hold_ff, hold_in;

   // captured request
   logic [7:0]          dev_ff, dev_in;
   logic [7:0]          port_ff, port_in;
   logic [7:0]          cnt_ff, cnt_in;
   logic [15:0]         ms_ff, ms_in;
   logic                on_ff, on_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   // set working values
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0]   st_ff, st_in;

   // channel store
   logic [NCH-1:0]      valid_ff, valid_in;
   logic                entry_valid_ff, entry_valid_in;
   logic                ram_wr_en, ram_rd_en;
   logic [CH_W-1:0]     ram_wr_addr, ram_rd_addr;
   chan_entry_type      ram_wr_data;
   logic [ENTRY_W-1:0]  ram_rd_data;
   chan_entry_type      entry;

   // walk counters and evaluation stage
   logic [CH_W:0]       rd_idx_ff, rd_idx_in;
   logic [DEV_W-1:0]    rd_dev_ff, rd_dev_in;
   logic [PORT_W-1:0]   rd_port_ff, rd_port_in;
   logic                eval_valid_ff, eval_valid_in;
   logic [CH_W-1:0]     eval_idx_ff, eval_idx_in;
   logic [DEV_W-1:0]    eval_dev_ff, eval_dev_in;
   logic [PORT_W-1:0]   eval_port_ff, eval_port_in;
   logic [5:0]          res_cnt_ff, res_cnt_in;

   // pending tick result, held until we know whether it is the last
   logic                pend_valid_ff, pend_valid_in;
   logic [1:0]          pend_dev_ff, pend_dev_in;
   logic [3:0]          pend_port_ff, pend_port_in;
   logic [5:0]          pend_level_ff, pend_level_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [1:0]          rsp_dev_ff, rsp_dev_in;
   logic [3:0]          rsp_port_ff, rsp_port_in;
   logic [5:0]          rsp_level_ff, rsp_level_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // helpers
   logic                set_reject;
   logic [CH_W-1:0]     set_ch;
   logic [25:0]         period_prod;
   logic                issue_ok;
   logic [3:0]          eval_dev_ext;
   logic [4:0]          eval_port_p1;
   logic                dev_active;
   logic                fire;
   logic                force_on;

   // request checks and channel index of a set item
   assign set_reject = (cnt_ff > MAX_PULSES) || (ms_ff > MAX_MS) || (dev_ff >= DEV_LIM) ||
                       (port_ff == 8'd0) || (port_ff > PORT_LIM);
   assign set_ch = CH_W'(CH_W'(dev_ff[DEV_W-1:0]) * PORTS_CH) + CH_W'(port_ff - 8'd1);
   assign period_prod = 26'(ms_ff) * 26'(US_PER_MS);

   // a channel never written reads as all zero
   assign entry = entry_valid_ff ? chan_entry_type'(ram_rd_data) : '0;

   // walk issue and firing test
   assign issue_ok     = (rd_idx_ff < NCH_CNT) && (res_cnt_ff < MAX_RES);
   assign eval_dev_ext = 4'(eval_dev_ff);
   assign eval_port_p1 = 5'(eval_port_ff) + 5'd1;
   assign dev_active   = (eval_dev_ext < MASK_DEVS) && mask_ff[eval_dev_ext[1:0]];
   assign fire = eval_valid_ff && dev_active && (res_cnt_ff < MAX_RES) &&
                 (entry.rem_edges != '0) && (entry.next_change < now_ff) &&
                 (entry.start_time < now_ff);
   assign force_on = !on_ff || (entry.rem_edges != '0);

   assign sts.set_reject = set_reject;
   assign sts.walk_done  = !eval_valid_ff && !issue_ok;

   // next-state logic
   always_comb begin
      mask_in        = mask_ff;
      hold_in        = hold_ff;
      dev_in         = dev_ff;
      port_in        = port_ff;
      cnt_in         = cnt_ff;
      ms_in          = ms_ff;
      on_in          = on_ff;
      now_in         = now_ff;
      period_in      = period_ff;
      st_in          = st_ff;
      valid_in       = valid_ff;
      entry_valid_in = entry_valid_ff;
      rd_idx_in      = rd_idx_ff;
      rd_dev_in      = rd_dev_ff;
      rd_port_in     = rd_port_ff;
      eval_valid_in  = 1'b0;
      eval_idx_in    = eval_idx_ff;
      eval_dev_in    = eval_dev_ff;
      eval_port_in   = eval_port_ff;
      res_cnt_in     = res_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_dev_in    = pend_dev_ff;
      pend_port_in   = pend_port_ff;
      pend_level_in  = pend_level_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_dev_in     = rsp_dev_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_wr_addr    = set_ch;
      ram_rd_addr    = set_ch;
      ram_wr_data    = '0;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_MASK: mask_in = csr_wdata[3:0];
            CSR_HOLD_DELAY:  hold_in = csr_wdata;
            default:         hold_in = hold_ff;
         endcase
      end

      // take a new item
      if (cmd.capture) begin
         dev_in        = req_device;
         port_in       = req_port;
         cnt_in        = req_num_pulses;
         ms_in         = req_pulse_time_ms;
         on_in         = req_port_is_on;
         now_in        = req_time_us;
         rd_idx_in     = '0;
         rd_dev_in     = '0;
         rd_port_in    = '0;
         res_cnt_in    = '0;
         pend_valid_in = 1'b0;
      end

      // set: check, then read the channel
      if (cmd.set_check) begin
         period_in = period_prod[PERIOD_W-1:0];
         if (set_reject) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = RES_STATUS;
            rsp_dev_in    = 2'd0;
            rsp_port_in   = 4'd0;
            rsp_level_in  = OFF_LEVEL;
            rsp_status_in = ST_REJECT;
            rsp_last_in   = 1'b1;
         end else begin
            ram_rd_en      = 1'b1;
            entry_valid_in = valid_ff[set_ch];
         end
      end

      // set: force the channel on if needed, fix the start time
      if (cmd.set_load) begin
         if (force_on) begin
            st_in         = sat_add48(now_ff, TIME_W'(hold_ff));
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = RES_FORCE_ON;
            rsp_dev_in    = dev_ff[1:0];
            rsp_port_in   = port_ff[3:0];
            rsp_level_in  = ON_LEVEL;
            rsp_status_in = ST_ACCEPT;
            rsp_last_in   = 1'b0;
         end else begin
            st_in = now_ff;
         end
      end

      // set: store the new train and acknowledge
      if (cmd.set_store) begin
         ram_wr_en               = 1'b1;
         ram_wr_addr             = set_ch;
         ram_wr_data.rem_edges   = {cnt_ff[5:0], 1'b0};
         ram_wr_data.period_us   = period_ff;
         ram_wr_data.start_time  = st_ff;
         ram_wr_data.next_change = sat_add48(st_ff, TIME_W'(period_ff));
         valid_in[set_ch]        = 1'b1;
         rsp_valid_in            = 1'b1;
         rsp_kind_in             = RES_STATUS;
         rsp_dev_in              = dev_ff[1:0];
         rsp_port_in             = port_ff[3:0];
         rsp_level_in            = OFF_LEVEL;
         rsp_status_in           = ST_ACCEPT;
         rsp_last_in             = 1'b1;
      end

      // tick: issue one channel read per cycle
      if (cmd.walk_step && issue_ok) begin
         ram_rd_en      = 1'b1;
         ram_rd_addr    = rd_idx_ff[CH_W-1:0];
         entry_valid_in = valid_ff[rd_idx_ff[CH_W-1:0]];
         eval_valid_in  = 1'b1;
         eval_idx_in    = rd_idx_ff[CH_W-1:0];
         eval_dev_in    = rd_dev_ff;
         eval_port_in   = rd_port_ff;
         rd_idx_in      = rd_idx_ff + 1'b1;
         if (rd_port_ff == PORT_LAST) begin
            rd_port_in = '0;
            rd_dev_in  = rd_dev_ff + 1'b1;
         end else begin
            rd_port_in = rd_port_ff + 1'b1;
         end
      end

      // tick: evaluate the channel read last cycle
      if (fire) begin
         ram_wr_en               = 1'b1;
         ram_wr_addr             = eval_idx_ff;
         ram_wr_data.rem_edges   = entry.rem_edges - 1'b1;
         ram_wr_data.period_us   = entry.period_us;
         ram_wr_data.start_time  = entry.start_time;
         ram_wr_data.next_change = sat_add48(now_ff, TIME_W'(entry.period_us));
         valid_in[eval_idx_ff]   = 1'b1;
         res_cnt_in              = res_cnt_ff + 1'b1;
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = RES_LEVEL;
            rsp_dev_in    = pend_dev_ff;
            rsp_port_in   = pend_port_ff;
            rsp_level_in  = pend_level_ff;
            rsp_status_in = ST_ACCEPT;
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_dev_in   = eval_dev_ext[1:0];
         pend_port_in  = eval_port_p1[3:0];
         pend_level_in = entry.rem_edges[0] ? ON_LEVEL : OFF_LEVEL;
      end

      // tick: flush the held result as the last one
      if (cmd.walk_finish && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = RES_LEVEL;
         rsp_dev_in    = pend_dev_ff;
         rsp_port_in   = pend_port_ff;
         rsp_level_in  = pend_level_ff;
         rsp_status_in = ST_ACCEPT;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= 4'd0;
         hold_ff       <= HOLD_RESET;
         valid_ff      <= '0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_cnt_ff    <= '0;
         rd_idx_ff     <= '0;
      end else begin
         mask_ff       <= mask_in;
         hold_ff       <= hold_in;
         valid_ff      <= valid_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_cnt_ff    <= res_cnt_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dev_ff         <= dev_in;
      port_ff        <= port_in;
      cnt_ff         <= cnt_in;
      ms_ff          <= ms_in;
      on_ff          <= on_in;
      now_ff         <= now_in;
      period_ff      <= period_in;
      st_ff          <= st_in;
      entry_valid_ff <= entry_valid_in;
      rd_dev_ff      <= rd_dev_in;
      rd_port_ff     <= rd_port_in;
      eval_idx_ff    <= eval_idx_in;
      eval_dev_ff    <= eval_dev_in;
      eval_port_ff   <= eval_port_in;
      pend_dev_ff    <= pend_dev_in;
      pend_port_ff   <= pend_port_in;
      pend_level_ff  <= pend_level_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_dev_ff     <= rsp_dev_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // channel memory
   mpts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NCH)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_device  = rsp_dev_ff;
   assign rsp_out_port    = rsp_port_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/multichannel_pulse_train_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// multichannel_pulse_train_scheduler_top: relay pulse train scheduler
// Schedules toggle trains on DEVICES x PORTS channels from set and tick
// items; a controller sequences a datapath around one channel memory.
//
//   Channel   Ports                          Flow control
//   -------   ----------------------------   ----------------------------
//   request   start, busy, req_*             taken when start && !busy
//   result    rsp_valid, rsp_*               one-cycle strobe, no backpressure
//   config    csr_wr_en, csr_index, csr_wdata  written on csr_wr_en
//
// A set item steps through check, load and store, a rejected one only the
// check; its results are registered and appear in the cycle after the one
// that produces them. The walk of a tick item reads one channel per cycle
// through the single read port of the channel memory. Synchronous active-high
// reset clears the controller, the active mask and the channel valid bits,
// and loads HOLD_RESET into the hold delay; channels read as zero until
// first written. Results cannot be stalled; at most one is produced per cycle.
// ---------------------------------------------------------------------------
module multichannel_pulse_train_scheduler_top #(
   parameter int DEVICES = 4,
   parameter int PORTS   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [7:0]  req_device,
   input  logic [7:0]  req_port,
   input  logic [7:0]  req_num_pulses,
   input  logic [15:0] req_pulse_time_ms,
   input  logic        req_port_is_on,
   input  logic [47:0] req_time_us,
   output logic        rsp_valid,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_out_device,
   output logic [3:0]  rsp_out_port,
   output logic [5:0]  rsp_level,
   output logic        rsp_status,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import mpts_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencing
   mpts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd),
      .sts      (sts)
   );

   // datapath and channel store
   mpts_dp #(
      .DEVICES (DEVICES),
      .PORTS   (PORTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_device        (req_device),
      .req_port          (req_port),
      .req_num_pulses    (req_num_pulses),
      .req_pulse_time_ms (req_pulse_time_ms),
      .req_port_is_on    (req_port_is_on),
      .req_time_us       (req_time_us),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_device    (rsp_out_device),
      .rsp_out_port      (rsp_out_port),
      .rsp_level         (rsp_level),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule
